// File: design/ahfr_pkg.sv
package ahfr_pkg;

    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 3;
    localparam int LEN_W    = 9;
    localparam int CFG_IDX_W = 2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_DATA     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_GOOD     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FCS_ERR  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SHORT    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ABORT    = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FLAG     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STATION  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PROTOCOL = 2'd3;

    localparam logic [BYTE_W-1:0] FLAG_RESET   = 8'h7E;
    localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'h7D;
    localparam logic [BYTE_W-1:0] ESC_XOR      = 8'h20;

    localparam logic [15:0] FCS_INIT = 16'hFFFF;
    localparam logic [15:0] FCS_GOOD = 16'hF0B8;
    localparam logic [15:0] FCS_POLY = 16'h8408;
    localparam int          MIN_FRAME = 5;

    typedef logic [BYTE_W-1:0] t_byte;

    typedef struct packed {
        t_byte flag_value;
        t_byte escape_value;
        t_byte station_address;
        t_byte protocol_id;
    } t_cfg;

    typedef struct packed {
        logic  valid;
        t_byte line_byte;
    } t_in_beat;

    // one byte of reflected CRC-16 (PPP FCS)
    function automatic logic [15:0] fcs_update(input logic [15:0] fcs, input t_byte b);
        logic [15:0] f;
        f = fcs ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (f[0]) begin
                f = (f >> 1) ^ FCS_POLY;
            end else begin
                f = f >> 1;
            end
        end
        return f;
    endfunction

endpackage

// File: design/ahfr_ifs.sv
interface ahfr_byte_if;
    logic                valid;
    logic                ready;
    logic [7:0]          line_byte;

    modport source (output valid, output line_byte, input ready);
    modport sink   (input valid, input line_byte, output ready);
endinterface

interface ahfr_res_if;
    logic                valid;
    logic                ready;
    logic [2:0]          kind;
    logic [7:0]          data_byte;
    logic [8:0]          frame_length;
    logic                address_match;

    modport source (output valid, output kind, output data_byte, output frame_length,
                    output address_match, input ready);
    modport sink   (input valid, input kind, input data_byte, input frame_length,
                    input address_match, output ready);
endinterface

interface ahfr_cfg_if;
    logic                valid;
    logic                ready;
    logic [1:0]          index;
    logic [7:0]          data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/ahfr_cfg_regs.sv
module ahfr_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ahfr_cfg_if.sink      i_cfg,
    output ahfr_pkg::t_cfg o_cfg
);

    ahfr_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flag_value      <= ahfr_pkg::FLAG_RESET;
            r_cfg.escape_value    <= ahfr_pkg::ESCAPE_RESET;
            r_cfg.station_address <= '0;
            r_cfg.protocol_id     <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                ahfr_pkg::REG_FLAG:     r_cfg.flag_value      <= i_cfg.data;
                ahfr_pkg::REG_ESCAPE:   r_cfg.escape_value    <= i_cfg.data;
                ahfr_pkg::REG_STATION:  r_cfg.station_address <= i_cfg.data;
                ahfr_pkg::REG_PROTOCOL: r_cfg.protocol_id     <= i_cfg.data;
                default: ;
            endcase
        end
    end

endmodule

// File: design/ahfr_in_stage.sv
module ahfr_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ahfr_byte_if.sink         i_rx,
    input  logic              i_take,
    output ahfr_pkg::t_in_beat o_beat
);

    logic          r_valid;
    ahfr_pkg::t_byte r_byte;

    // refill in the same cycle the held beat moves on
    assign i_rx.ready = !r_valid || i_take;

    assign o_beat.valid     = r_valid;
    assign o_beat.line_byte = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_byte <= i_rx.line_byte;
        end
    end

endmodule

// File: design/ahfr_deframer.sv
module ahfr_deframer #(
    parameter int MAX_PAYLOAD = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ahfr_pkg::t_cfg     i_cfg,
    input  ahfr_pkg::t_in_beat i_beat,
    output logic               o_take,
    ahfr_res_if.source         o_res
);

    localparam int BUF_LIMIT = MAX_PAYLOAD + 4;
    localparam int CNT_W     = $clog2(BUF_LIMIT + 1);

    localparam logic [1:0] MODE_HUNT = 2'd0;
    localparam logic [1:0] MODE_DATA = 2'd1;
    localparam logic [1:0] MODE_ESC  = 2'd2;

    logic [1:0]       r_mode, n_mode;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [15:0]      r_fcs, n_fcs;
    logic             r_first_ok, n_first_ok;
    logic             r_second_ok, n_second_ok;

    logic             r_out_valid;
    logic [2:0]       r_kind, n_kind;
    logic [7:0]       r_data, n_data;
    logic [8:0]       r_len, n_len;
    logic             r_match, n_match;

    logic             emit;
    logic             out_free;
    logic             process;
    logic             is_flag;
    logic             full;
    logic [7:0]       b;
    logic [7:0]       store_b;
    logic             do_store;
    logic [CNT_W+8:0] cnt_ext;
    logic [8:0]       cnt_len;
    logic             match_now;

    assign out_free = !r_out_valid || o_res.ready;
    assign o_take   = out_free;
    assign process  = i_beat.valid && out_free;

    assign b         = i_beat.line_byte;
    assign is_flag   = (b == i_cfg.flag_value);
    assign full      = (r_cnt >= CNT_W'(BUF_LIMIT));
    assign cnt_ext   = {9'd0, r_cnt};
    assign cnt_len   = cnt_ext[8:0];
    assign match_now = r_first_ok && r_second_ok;

    always_comb begin
        n_mode      = r_mode;
        n_cnt       = r_cnt;
        n_fcs       = r_fcs;
        n_first_ok  = r_first_ok;
        n_second_ok = r_second_ok;
        emit        = 1'b0;
        n_kind      = ahfr_pkg::KIND_DATA;
        n_data      = '0;
        n_len       = '0;
        n_match     = 1'b0;
        do_store    = 1'b0;
        store_b     = b;

        if (is_flag) begin
            if (r_cnt != '0) begin
                emit    = 1'b1;
                n_len   = cnt_len;
                n_match = match_now;
                if (r_cnt >= CNT_W'(ahfr_pkg::MIN_FRAME)) begin
                    n_kind = (r_fcs == ahfr_pkg::FCS_GOOD) ? ahfr_pkg::KIND_GOOD
                                                           : ahfr_pkg::KIND_FCS_ERR;
                end else begin
                    n_kind = ahfr_pkg::KIND_SHORT;
                end
            end
            n_cnt       = '0;
            n_fcs       = ahfr_pkg::FCS_INIT;
            n_first_ok  = 1'b0;
            n_second_ok = 1'b0;
            n_mode      = MODE_DATA;
        end else begin
            unique case (r_mode)
                MODE_DATA: begin
                    if (b == i_cfg.escape_value) begin
                        n_mode = MODE_ESC;
                    end else begin
                        do_store = 1'b1;
                    end
                end
                MODE_ESC: begin
                    do_store = 1'b1;
                    store_b  = b ^ ahfr_pkg::ESC_XOR;
                end
                default: begin
                    n_mode = MODE_HUNT;
                end
            endcase

            if (do_store) begin
                emit = 1'b1;
                if (full) begin
                    n_kind      = ahfr_pkg::KIND_ABORT;
                    n_len       = cnt_len;
                    n_match     = match_now;
                    n_cnt       = '0;
                    n_fcs       = ahfr_pkg::FCS_INIT;
                    n_first_ok  = 1'b0;
                    n_second_ok = 1'b0;
                    n_mode      = MODE_HUNT;
                end else begin
                    if (r_cnt == '0) begin
                        n_first_ok = (store_b == i_cfg.station_address);
                    end else if (r_cnt == CNT_W'(1)) begin
                        n_second_ok = (store_b == i_cfg.protocol_id);
                    end
                    n_fcs  = ahfr_pkg::fcs_update(r_fcs, store_b);
                    n_cnt  = r_cnt + CNT_W'(1);
                    n_mode = MODE_DATA;
                    n_kind = ahfr_pkg::KIND_DATA;
                    n_data = store_b;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_HUNT;
            r_cnt       <= '0;
            r_fcs       <= ahfr_pkg::FCS_INIT;
            r_first_ok  <= 1'b0;
            r_second_ok <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (process) begin
                r_mode      <= n_mode;
                r_cnt       <= n_cnt;
                r_fcs       <= n_fcs;
                r_first_ok  <= n_first_ok;
                r_second_ok <= n_second_ok;
            end
            if (process && emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (process && emit) begin
            r_kind  <= n_kind;
            r_data  <= n_data;
            r_len   <= n_len;
            r_match <= n_match;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.kind          = r_kind;
    assign o_res.data_byte     = r_data;
    assign o_res.frame_length  = r_len;
    assign o_res.address_match = r_match;

endmodule

// File: design/async_hdlc_frame_receiver.sv
// Byte-stuffed asynchronous HDLC receiver with PPP FCS-16 check. One raw line byte is
// taken per beat on i_rx and, with the result side not stalled, a new byte is taken every
// cycle; a byte passes an input register and one step of unstuffing, CRC and frame state
// logic, and its result (if any) is registered onto o_res. Each stored byte gives a data
// result; a flag closing a frame of five or more bytes gives good or FCS error, a shorter
// nonempty frame gives too short, and a data byte arriving with MAX_PAYLOAD+4 bytes held
// gives an overflow abort and a return to flag hunt. Flag, escape, station address and
// protocol id must be written over i_cfg only while idle; the block does not enforce it.
module async_hdlc_frame_receiver #(
    parameter int MAX_PAYLOAD = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ahfr_byte_if.sink   i_rx,
    ahfr_res_if.source  o_res,
    ahfr_cfg_if.sink    i_cfg
);

    ahfr_pkg::t_cfg     cfg;
    ahfr_pkg::t_in_beat beat;
    logic               take;

    ahfr_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    ahfr_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_take  (take),
        .o_beat  (beat)
    );

    ahfr_deframer #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_deframer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_beat  (beat),
        .o_take  (take),
        .o_res   (o_res)
    );

endmodule

// File: tb/async_hdlc_frame_receiver_test.sv
`timescale 1ns / 100ps

module async_hdlc_frame_receiver_test;

    localparam int MAX_PAYLOAD    = 256;
    localparam int BUF_LIMIT      = MAX_PAYLOAD + 4;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 8;

    typedef enum logic [1:0] {RX_HUNT, RX_DATA, RX_ESC} t_rx_mode;

    typedef struct packed {
        logic [ahfr_pkg::KIND_W-1:0] kind;
        ahfr_pkg::t_byte             data_byte;
        logic [ahfr_pkg::LEN_W-1:0]  frame_length;
        logic                        address_match;
    } t_rx_event;

    logic i_clk;
    logic i_rst_n;

    ahfr_byte_if rx_if();
    ahfr_res_if  res_if();
    ahfr_cfg_if  cfg_if();

    async_hdlc_frame_receiver #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_rx   (rx_if),
        .o_res  (res_if),
        .i_cfg  (cfg_if)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // line bytes waiting to be driven, and deframer events still owed by the block
    ahfr_pkg::t_byte line_q[$];
    t_rx_event       exp_events[$];

    // deframer state as the block should hold it
    t_rx_mode       p_mode;
    int             p_count;
    logic [15:0]    p_fcs;
    logic           p_first_ok;
    logic           p_second_ok;
    ahfr_pkg::t_cfg p_cfg;

    // register values as seen by the stimulus side
    ahfr_pkg::t_cfg s_cfg;

    int errors;
    int idle_cycles;
    int bytes_sent;
    int bytes_queued;
    int cfg_writes;
    int kind_seen[5];
    bit quiet;
    bit rx_took;
    int rx_gap;
    int res_stall;

    function automatic logic [15:0] crc_step(input logic [15:0] c, input ahfr_pkg::t_byte b);
        logic fb;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb) begin
                c = c ^ ahfr_pkg::FCS_POLY;
            end
        end
        return c;
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void clear_frame_model();
        p_count     = 0;
        p_fcs       = ahfr_pkg::FCS_INIT;
        p_first_ok  = 1'b0;
        p_second_ok = 1'b0;
    endfunction

    function automatic void expect_event(input logic [ahfr_pkg::KIND_W-1:0] kind,
                                         input ahfr_pkg::t_byte data,
                                         input int len, input logic match);
        t_rx_event e;
        e.kind          = kind;
        e.data_byte     = data;
        e.frame_length  = len[ahfr_pkg::LEN_W-1:0];
        e.address_match = match;
        exp_events.push_back(e);
    endfunction

    function automatic void store_model(input ahfr_pkg::t_byte b);
        if (p_count >= BUF_LIMIT) begin
            expect_event(ahfr_pkg::KIND_ABORT, '0, p_count, p_first_ok && p_second_ok);
            clear_frame_model();
            p_mode = RX_HUNT;
        end else begin
            if (p_count == 0) begin
                p_first_ok = (b == p_cfg.station_address);
            end else if (p_count == 1) begin
                p_second_ok = (b == p_cfg.protocol_id);
            end
            p_fcs   = crc_step(p_fcs, b);
            p_count = p_count + 1;
            p_mode  = RX_DATA;
            expect_event(ahfr_pkg::KIND_DATA, b, 0, 1'b0);
        end
    endfunction

    function automatic void deframe_byte(input ahfr_pkg::t_byte b);
        if (b == p_cfg.flag_value) begin
            // flag wins over escape, and closes whatever is open
            if (p_count >= ahfr_pkg::MIN_FRAME) begin
                expect_event((p_fcs == ahfr_pkg::FCS_GOOD) ? ahfr_pkg::KIND_GOOD
                                                           : ahfr_pkg::KIND_FCS_ERR,
                             '0, p_count, p_first_ok && p_second_ok);
            end else if (p_count > 0) begin
                expect_event(ahfr_pkg::KIND_SHORT, '0, p_count, p_first_ok && p_second_ok);
            end
            clear_frame_model();
            p_mode = RX_DATA;
        end else begin
            case (p_mode)
                RX_DATA: begin
                    if (b == p_cfg.escape_value) begin
                        p_mode = RX_ESC;
                    end else begin
                        store_model(b);
                    end
                end
                RX_ESC: begin
                    store_model(b ^ ahfr_pkg::ESC_XOR);
                end
                default: begin
                    p_mode = RX_HUNT;
                end
            endcase
        end
    endfunction

    // predictor, checker and watchdog, all on the rising edge
    always @(posedge i_clk) begin
        t_rx_event got;
        t_rx_event want;
        bit        cfg_took;
        bit        res_took;
        if (!i_rst_n) begin
            p_mode              = RX_HUNT;
            clear_frame_model();
            p_cfg.flag_value      = ahfr_pkg::FLAG_RESET;
            p_cfg.escape_value    = ahfr_pkg::ESCAPE_RESET;
            p_cfg.station_address = '0;
            p_cfg.protocol_id     = '0;
            rx_took             = 1'b0;
            idle_cycles         = 0;
        end else begin
            rx_took  = rx_if.valid && rx_if.ready;
            cfg_took = cfg_if.valid && cfg_if.ready;
            res_took = res_if.valid && res_if.ready;
            if (cfg_took) begin
                cfg_writes++;
                case (cfg_if.index)
                    ahfr_pkg::REG_FLAG:     p_cfg.flag_value      = cfg_if.data;
                    ahfr_pkg::REG_ESCAPE:   p_cfg.escape_value    = cfg_if.data;
                    ahfr_pkg::REG_STATION:  p_cfg.station_address = cfg_if.data;
                    ahfr_pkg::REG_PROTOCOL: p_cfg.protocol_id     = cfg_if.data;
                    default: ;
                endcase
            end
            if (rx_took) begin
                deframe_byte(rx_if.line_byte);
                void'(line_q.pop_front());
                bytes_sent++;
            end
            if (res_took) begin
                got.kind          = res_if.kind;
                got.data_byte     = res_if.data_byte;
                got.frame_length  = res_if.frame_length;
                got.address_match = res_if.address_match;
                if (got.kind <= ahfr_pkg::KIND_ABORT) begin
                    kind_seen[got.kind]++;
                end
                if (exp_events.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("%0t: unexpected result kind=%0d data=%02h len=%0d match=%0b",
                                 $time, got.kind, got.data_byte, got.frame_length,
                                 got.address_match);
                    end
                end else begin
                    want = exp_events.pop_front();
                    if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
                        got.frame_length !== want.frame_length ||
                        got.address_match !== want.address_match) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("%0t: mismatch exp kind=%0d data=%02h len=%0d match=%0b",
                                     $time, want.kind, want.data_byte, want.frame_length,
                                     want.address_match);
                            $display("%0t:          got kind=%0d data=%02h len=%0d match=%0b",
                                     $time, got.kind, got.data_byte, got.frame_length,
                                     got.address_match);
                        end
                    end
                end
            end
            if (rx_took || cfg_took || res_took) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("watchdog: no beat for %0d cycles", idle_cycles);
                    $display("FAIL async_hdlc_frame_receiver");
                    $finish;
                end
            end
        end
    end

    // line byte driver
    always @(negedge i_clk) begin
        if (i_rst_n && !(rx_if.valid && !rx_took)) begin
            if (rx_gap > 0) begin
                rx_gap--;
                rx_if.valid <= 1'b0;
            end else if (line_q.size() > 0) begin
                rx_if.valid     <= 1'b1;
                rx_if.line_byte <= line_q[0];
                rx_gap = pick_gap();
            end else begin
                rx_if.valid <= 1'b0;
            end
        end
    end

    // result side backpressure
    always @(negedge i_clk) begin
        if (res_stall > 0) begin
            res_stall--;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
            if (!quiet && $urandom_range(0, 99) < 20) begin
                res_stall = pick_gap();
            end
        end
    end

    function automatic void send(input ahfr_pkg::t_byte b);
        line_q.push_back(b);
        bytes_queued++;
    endfunction

    function automatic void emit_stuffed(input ahfr_pkg::t_byte b);
        if (b == s_cfg.flag_value || b == s_cfg.escape_value ||
            ($urandom_range(0, 15) == 0 && (b ^ ahfr_pkg::ESC_XOR) != s_cfg.flag_value)) begin
            send(s_cfg.escape_value);
            send(b ^ ahfr_pkg::ESC_XOR);
        end else begin
            send(b);
        end
    endfunction

    function automatic void add_frame(input int n_data, input bit good, input bit hdr_ok);
        ahfr_pkg::t_byte body[$];
        logic [15:0]     c;
        body.push_back(hdr_ok ? s_cfg.station_address : ahfr_pkg::t_byte'($urandom));
        body.push_back(hdr_ok ? s_cfg.protocol_id : ahfr_pkg::t_byte'($urandom));
        repeat (n_data) body.push_back(ahfr_pkg::t_byte'($urandom));
        c = ahfr_pkg::FCS_INIT;
        foreach (body[i]) c = crc_step(c, body[i]);
        c = ~c;
        if (!good) begin
            c = c ^ (16'h1 << $urandom_range(0, 15));
        end
        body.push_back(c[7:0]);
        body.push_back(c[15:8]);
        foreach (body[i]) emit_stuffed(body[i]);
        send(s_cfg.flag_value);
    endfunction

    function automatic void add_short();
        repeat ($urandom_range(1, 4)) emit_stuffed(ahfr_pkg::t_byte'($urandom));
        send(s_cfg.flag_value);
    endfunction

    function automatic ahfr_pkg::t_byte non_flag();
        ahfr_pkg::t_byte b;
        b = ahfr_pkg::t_byte'($urandom);
        if (b == s_cfg.flag_value) begin
            b = b ^ 8'h01;
        end
        return b;
    endfunction

    // 260 stored bytes, then an escape with the buffer full, then hunt noise
    function automatic void add_overflow();
        repeat (BUF_LIMIT) emit_stuffed(ahfr_pkg::t_byte'($urandom));
        send(s_cfg.escape_value);
        send(non_flag());
        repeat ($urandom_range(1, 4)) send(non_flag());
        send(s_cfg.flag_value);
    endfunction

    function automatic void random_mix(input int budget);
        int limit;
        int r;
        limit = bytes_queued + budget;
        while (bytes_queued < limit) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 7) == 0) begin
                send(s_cfg.flag_value);
            end
            if (r < 55) begin
                add_frame(($urandom_range(0, 99) < 85) ? $urandom_range(0, 10)
                                                      : $urandom_range(11, 40),
                          1'b1, $urandom_range(0, 4) != 0);
            end else if (r < 70) begin
                add_frame($urandom_range(1, 10), 1'b0, $urandom_range(0, 1));
            end else if (r < 80) begin
                add_short();
            end else if (r < 90) begin
                repeat ($urandom_range(1, 6)) begin
                    case ($urandom_range(0, 5))
                        0:       send(s_cfg.escape_value);
                        1:       send(s_cfg.flag_value);
                        default: send(ahfr_pkg::t_byte'($urandom));
                    endcase
                end
            end else if (r < 96) begin
                // escape directly before a flag
                repeat ($urandom_range(0, 3)) emit_stuffed(ahfr_pkg::t_byte'($urandom));
                send(s_cfg.escape_value);
                send(s_cfg.flag_value);
            end else begin
                send(s_cfg.flag_value);
                send(s_cfg.flag_value);
            end
        end
    endfunction

    task automatic wait_idle();
        @(negedge i_clk);
        while (line_q.size() != 0 || rx_if.valid || exp_events.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [ahfr_pkg::CFG_IDX_W-1:0] idx,
                             input ahfr_pkg::t_byte val);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
        case (idx)
            ahfr_pkg::REG_FLAG:     s_cfg.flag_value      = val;
            ahfr_pkg::REG_ESCAPE:   s_cfg.escape_value    = val;
            ahfr_pkg::REG_STATION:  s_cfg.station_address = val;
            ahfr_pkg::REG_PROTOCOL: s_cfg.protocol_id     = val;
            default: ;
        endcase
    endtask

    task automatic write_all(input ahfr_pkg::t_byte flag, input ahfr_pkg::t_byte esc,
                             input ahfr_pkg::t_byte sta, input ahfr_pkg::t_byte proto);
        write_reg(ahfr_pkg::REG_FLAG, flag);
        write_reg(ahfr_pkg::REG_ESCAPE, esc);
        write_reg(ahfr_pkg::REG_STATION, sta);
        write_reg(ahfr_pkg::REG_PROTOCOL, proto);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        rx_if.valid     = 1'b0;
        rx_if.line_byte = '0;
        res_if.ready    = 1'b0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = ahfr_pkg::REG_FLAG;
        cfg_if.data     = '0;
        errors          = 0;
        bytes_sent      = 0;
        bytes_queued    = 0;
        cfg_writes      = 0;
        rx_gap          = 0;
        res_stall       = 0;
        quiet           = 1'b0;
        foreach (kind_seen[k]) kind_seen[k] = 0;
        s_cfg.flag_value      = ahfr_pkg::FLAG_RESET;
        s_cfg.escape_value    = ahfr_pkg::ESCAPE_RESET;
        s_cfg.station_address = '0;
        s_cfg.protocol_id     = '0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at reset register values
        send(8'h00); send(8'hFF); send(ahfr_pkg::ESCAPE_RESET); send(8'h41); // ignored, hunting
        send(ahfr_pkg::FLAG_RESET); send(ahfr_pkg::FLAG_RESET);              // empty frames
        send(8'h00); send(8'hFF); send(ahfr_pkg::FLAG_RESET);                // too short
        send(8'h11); send(ahfr_pkg::ESCAPE_RESET); send(ahfr_pkg::FLAG_RESET); // escape, flag
        send(ahfr_pkg::ESCAPE_RESET); send(8'h5E);
        send(ahfr_pkg::ESCAPE_RESET); send(8'h5D);
        send(ahfr_pkg::ESCAPE_RESET); send(8'h00); send(ahfr_pkg::FLAG_RESET); // escaped specials
        add_frame(1, 1'b1, 1'b1);
        add_frame(2, 1'b0, 1'b1);
        random_mix(15);

        for (int ph = 0; ph < 6; ph++) begin
            wait_idle();
            case (ph)
                0: write_all(8'h7E, 8'h7D, 8'hFF, 8'h03);
                1: write_all(8'h00, 8'hFF, 8'h00, 8'hFF);
                2: write_all(8'hFF, 8'h00, ahfr_pkg::t_byte'($urandom),
                             ahfr_pkg::t_byte'($urandom));
                3: write_all(8'h55, 8'h55, ahfr_pkg::t_byte'($urandom),
                             ahfr_pkg::t_byte'($urandom));  // flag == escape
                4: write_all(ahfr_pkg::t_byte'($urandom), ahfr_pkg::t_byte'($urandom),
                             ahfr_pkg::t_byte'($urandom), ahfr_pkg::t_byte'($urandom));
                default: write_all(8'h7E, 8'h7D, 8'hFF, 8'h03);
            endcase
            quiet = (ph == 2);
            send(s_cfg.flag_value);
            if (ph == 5) begin
                // fills the buffer exactly, then overflows it
                add_overflow();
                send(s_cfg.flag_value);
            end
            random_mix(8);
        end

        wait_idle();
        if (exp_events.size() != 0) begin
            $display("%0d expected results never arrived", exp_events.size());
            errors += exp_events.size();
        end
        $display("Run covered %0d line bytes and %0d register writes over 7 settings",
                 bytes_sent, cfg_writes);
        $display("Results: %0d data, %0d good, %0d fcs error, %0d too short, %0d abort",
                 kind_seen[ahfr_pkg::KIND_DATA], kind_seen[ahfr_pkg::KIND_GOOD],
                 kind_seen[ahfr_pkg::KIND_FCS_ERR], kind_seen[ahfr_pkg::KIND_SHORT],
                 kind_seen[ahfr_pkg::KIND_ABORT]);
        if (errors == 0) begin
            $display("PASS async_hdlc_frame_receiver");
        end else begin
            $display("%0d mismatches", errors);
            $display("FAIL async_hdlc_frame_receiver");
        end
        $finish;
    end

endmodule
